// ===== rtl/core/fixed_array_insert_delete_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array insert/delete/search core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_ARRAY_INSERT_DELETE_SEARCH_CORE_DEFINES_SVH
`define FIXED_ARRAY_INSERT_DELETE_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define FAIDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("faids assertion failed");

// Next-cycle implication.
`define FAIDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("faids assertion failed");

`endif

// ===== rtl/core/faids_pkg.sv =====
// ----------------------------------------------------------------------------
// faids_pkg
// Types and constants shared by the array insert/delete/search core.
// ----------------------------------------------------------------------------
package faids_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CAP_W     = 5;
  localparam int IN_VAL_W  = 32;
  localparam int POS_W     = 5;
  localparam int FIDX_W    = 4;
  localparam int ECOUNT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADPOS   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [IN_VAL_W-1:0] value;
    logic [POS_W-1:0]           position;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [FIDX_W-1:0]     found_index;
    logic [ECOUNT_W-1:0]   entry_count;
  } out_item_t;

endpackage

// ===== rtl/core/faids_ram.sv =====
// ----------------------------------------------------------------------------
// faids_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module faids_ram
  import faids_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [IW-1:0]          wr_addr_i,
  input  logic [VALUE_WIDTH-1:0] wr_data_i,
  input  logic                   rd_en_i,
  input  logic [IW-1:0]          rd_addr_i,
  output logic [VALUE_WIDTH-1:0] rd_data_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/fixed_array_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// fixed_array_insert_delete_search_core
// Ordered list of signed values in a DEPTH-entry store with insert at a
// 1-based position, delete by value and search by value.
// ----------------------------------------------------------------------------
// One item at a time. The entries sit in a single-port-read, single-port-write
// RAM with registered read data, so a search, a delete or a shifting insert
// walks the store one entry per cycle. A search stops at the first match; a
// delete reads on to the last entry and, if found, moves later entries down;
// an insert moves the entries from the top down to its position up by one,
// then writes the value (an append writes at once). A refused or empty-list
// item goes straight to its result. A new item is taken once the previous
// result is in the output register, even if it has not yet been collected.
module fixed_array_insert_delete_search_core
  import faids_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

`include "fixed_array_insert_delete_search_core_defines.svh"

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [CAP_W-1:0]       cap_q;
  logic [1:0]             act_q, act_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [IW-1:0]          at_q, at_d;
  logic [IW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   hit_q, hit_d;
  logic [IW-1:0]          idx_q, idx_d;
  status_e                st_q, st_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;

  logic                   rd_en, wr_en;
  logic [IW-1:0]          rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data, rd_data;

  logic [63:0]            val_ext;
  logic [VALUE_WIDTH-1:0] val_in;
  logic                   last_w, match_w, full_w, badpos_w, append_w;
  logic [PW-1:0]          pos_w, cnt_w;

  assign val_ext = {{(64 - IN_VAL_W){in_data_i.value[IN_VAL_W-1]}}, in_data_i.value};
  assign val_in  = val_ext[VALUE_WIDTH-1:0];

  assign pos_w    = PW'(in_data_i.position);
  assign cnt_w    = PW'(cnt_q);
  assign full_w   = (cnt_w >= PW'(cap_q)) || (cnt_q >= CW'(DEPTH));
  assign badpos_w = (pos_w == '0) || (pos_w > cnt_w + PW'(1));
  assign append_w = (pos_w == cnt_w + PW'(1));

  assign last_w  = ((CW'(ptr_q) + CW'(1)) == cnt_q);
  assign match_w = (rd_data == val_q);

  faids_ram #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    val_d       = val_q;
    at_d        = at_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    rd_addr     = ptr_q;
    wr_en       = 1'b0;
    wr_addr     = ptr_q;
    wr_data     = rd_data;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_data_i.action;
          val_d = val_in;
          at_d  = IW'(pos_w - PW'(1));
          hit_d = 1'b0;
          idx_d = '0;
          st_d  = ST_DONE;
          priority if (in_data_i.action == ACT_INSERT) begin
            priority if (full_w) begin
              st_d    = ST_FULL;
              state_d = S_DONE;
            end else if (badpos_w) begin
              st_d    = ST_BADPOS;
              state_d = S_DONE;
            end else if (append_w) begin
              state_d = S_PUT;
            end else begin
              // start the upward shift from the top entry
              rd_en   = 1'b1;
              rd_addr = IW'(cnt_q - CW'(1));
              ptr_d   = IW'(cnt_q - CW'(1));
              state_d = S_SHIFT;
            end
          end else if (in_data_i.action == ACT_DELETE ||
                       in_data_i.action == ACT_SEARCH) begin
            if (cnt_q == '0) begin
              st_d    = ST_NOTFOUND;
              state_d = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              ptr_d   = '0;
              state_d = S_SCAN;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // move entry ptr up by one, read the next one down until ptr reaches the insert position
        wr_en   = 1'b1;
        wr_addr = ptr_q + IW'(1);
        if (ptr_q == at_q) begin
          state_d = S_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q - IW'(1);
          ptr_d   = ptr_q - IW'(1);
        end
      end

      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = at_q;
        wr_data = val_q;
        cnt_d   = cnt_q + CW'(1);
        state_d = S_DONE;
      end

      S_SCAN: begin
        if (hit_q) begin
          // close the gap left by the deleted entry
          wr_en   = 1'b1;
          wr_addr = ptr_q - IW'(1);
        end
        if (!hit_q && match_w && act_q == ACT_SEARCH) begin
          idx_d   = ptr_q;
          state_d = S_DONE;
        end else begin
          if (!hit_q && match_w) begin
            hit_d = 1'b1;
            idx_d = ptr_q;
          end
          if (last_w) begin
            if (hit_q || match_w) begin
              cnt_d = cnt_q - CW'(1);
            end else begin
              st_d = ST_NOTFOUND;
            end
            state_d = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_q + IW'(1);
            ptr_d   = ptr_q + IW'(1);
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_data_d.status       = st_q;
          out_data_d.found_index  = FIDX_W'(idx_q);
          out_data_d.entry_count  = ECOUNT_W'(cnt_q);
          state_d                 = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    val_q      <= val_d;
    at_q       <= at_d;
    ptr_q      <= ptr_d;
    idx_q      <= idx_d;
    st_q       <= st_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  `FAIDS_ASSERT_NEXT(a_one_item_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  `FAIDS_ASSERT_NOW(a_no_write_when_idle, state_q == S_IDLE || state_q == S_DONE, !wr_en)
  `FAIDS_ASSERT_NEXT(a_count_moves_only_on_edit,
                     state_q != S_PUT && state_q != S_SCAN, $stable(cnt_q))
  `FAIDS_ASSERT_NOW(a_count_within_depth, 1'b1, cnt_q <= CW'(DEPTH))

endmodule
